// File: sv/msavg_pkg.sv
// Package with the shared types, constants and widths of the multichannel sample averager.
`timescale 1ns / 1ps

package msavg_pkg;

	// Channel and counter sizing.
	localparam int CHANNELS   = 4;
	localparam int COUNT_BITS = 16;
	localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	// Fixed field widths.
	localparam int SCALE_W  = 16;
	localparam int SUM_W    = 32;
	localparam int IRQ_W    = 32;
	localparam int SAMPLE_W = 16;
	localparam int AVG_W    = 16;

	// Divider sizing: the dividend is the scale times the sum.
	localparam int PROD_W = SCALE_W + SUM_W;
	localparam int DIV_W  = (COUNT_BITS > 16) ? COUNT_BITS : 16;
	localparam int STEP_W = $clog2(PROD_W);

	// Full scale is 2^15 - 1, so dividing by it folds the upper bits onto the lower bits.
	localparam int FOLD_W = 15;

	// Scaling constants.
	localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(61440);
	localparam logic [DIV_W-1:0]   FULL_SCALE  = DIV_W'(32767);
	localparam logic [DIV_W-1:0]   HALF_SCALE  = DIV_W'(32767 / 2);

	// Averages at or above this limit give a scaled result beyond the output range.
	localparam logic [PROD_W-1:0]  SAT_LIMIT   = PROD_W'(FULL_SCALE) << AVG_W;

	// Operation codes.
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_SEND   = 1'b1;

	// Input transaction.
	typedef struct packed {
		logic                       operation;
		logic [1:0]                 channel;
		logic signed [SAMPLE_W-1:0] sample;
		logic                       read_ok;
	} in_item_t;

	// Output transaction.
	typedef struct packed {
		logic [1:0]       out_channel;
		logic [AVG_W-1:0] average_value;
		logic [IRQ_W-1:0] interrupt_total;
		logic             last;
	} out_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic            sample_upd;
		logic            chan_load;
		logic            div_avg_start;
		logic            out_load;
		logic [CH_W-1:0] ch;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic cnt_zero;
		logic div_done;
	} dp_status_t;

endpackage

// File: sv/msavg_div.sv
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module msavg_div
	import msavg_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [PROD_W-1:0] dividend,
	input  logic [DIV_W-1:0]  divisor,
	output logic              busy,
	output logic              done,
	output logic [PROD_W-1:0] quotient
);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [PROD_W-1:0] quo_q;
	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  dvs_q;
	logic [DIV_W:0]    trial;
	logic              ge;
	logic [DIV_W:0]    diff;

	// One trial subtraction of the shifted remainder.
	always_comb begin
		trial = {rem_q, quo_q[PROD_W-1]};
		ge    = (trial >= {1'b0, dvs_q});
		diff  = trial - {1'b0, dvs_q};
	end

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == STEP_W'(PROD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				step_q <= step_q + 1'b1;
			end
		end
	end

	// Remainder and quotient shift registers.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[PROD_W-2:0], ge};
			rem_q <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: sv/msavg_dp.sv
// Datapath: channel accumulators, scale register, divider and output register.
`timescale 1ns / 1ps

module msavg_dp
	import msavg_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               scale_wr_en,
	input  logic [SCALE_W-1:0] scale_wr_data,
	input  in_item_t           in_data,
	input  dp_cmd_t            cmd,
	output dp_status_t         status,
	output out_item_t          out_data
);

	logic [SCALE_W-1:0]    scale_q;
	logic [SUM_W-1:0]      sum_q [CHANNELS];
	logic [COUNT_BITS-1:0] cnt_q [CHANNELS];
	logic [IRQ_W-1:0]      irq_q [CHANNELS];
	logic                  zero_q;
	out_item_t             out_q;

	logic [CH_W-1:0]     in_idx;
	logic                in_range;
	logic [CH_W-1:0]     idx;
	logic [SUM_W-1:0]    sample_val;
	logic [SUM_W:0]      sum_add;
	logic                div_start;
	logic [PROD_W-1:0]   div_dividend;
	logic [DIV_W-1:0]    div_divisor;
	logic                div_busy;
	logic                div_done;
	logic [PROD_W-1:0]   div_quo;
	logic [FOLD_W:0]     fold_hi;
	logic [FOLD_W-1:0]   fold_lo;
	logic [FOLD_W+1:0]   fold_sum;
	logic [FOLD_W+1:0]   full_one;
	logic [FOLD_W+1:0]   full_two;
	logic [FOLD_W+1:0]   scl_quo;
	logic [FOLD_W+1:0]   scl_rem;
	logic                round_up;
	logic [FOLD_W+1:0]   rounded;
	logic [AVG_W-1:0]    avg_val;

	// Shared channel selection for accumulation and for result formation.
	always_comb begin
		in_idx     = CH_W'(in_data.channel);
		in_range   = (32'(in_data.channel) < CHANNELS);
		idx        = cmd.sample_upd ? in_idx : cmd.ch;
		sample_val = in_data.sample[SAMPLE_W-1] ? '0
			: SUM_W'(unsigned'(in_data.sample));
		sum_add    = {1'b0, sum_q[idx]} + {1'b0, sample_val};
	end

	// Scale register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
		end else if (scale_wr_en) begin
			scale_q <= scale_wr_data;
		end
	end

	// Per-channel accumulators: updated by samples, cleared as each result is formed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				sum_q[i] <= '0;
				cnt_q[i] <= '0;
				irq_q[i] <= '0;
			end
		end else if (cmd.sample_upd && in_range) begin
			irq_q[idx] <= irq_q[idx] + 1'b1;
			if (in_data.read_ok && (cnt_q[idx] != '1)) begin
				sum_q[idx] <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
				cnt_q[idx] <= cnt_q[idx] + 1'b1;
			end
		end else if (cmd.chan_load) begin
			sum_q[idx] <= '0;
			cnt_q[idx] <= '0;
		end
	end

	// Remember whether the selected channel had no samples.
	always_ff @(posedge clk) begin
		if (cmd.chan_load) begin
			zero_q <= (cnt_q[idx] == '0);
		end
	end

	// The divider takes the scaled sum and the count of the selected channel
	// in the same cycle that the accumulators are cleared.
	always_comb begin
		div_start    = cmd.div_avg_start;
		div_dividend = PROD_W'(scale_q) * PROD_W'(sum_q[idx]);
		div_divisor  = DIV_W'(cnt_q[idx]);
	end

	msavg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Division by full scale: fold the upper bits onto the lower bits, then
	// correct by up to two subtractions. Rounding is half up, with saturation.
	always_comb begin
		fold_hi  = div_quo[2*FOLD_W:FOLD_W];
		fold_lo  = div_quo[FOLD_W-1:0];
		fold_sum = {1'b0, fold_hi} + {2'b0, fold_lo};
		full_one = (FOLD_W+2)'(FULL_SCALE);
		full_two = {full_one[FOLD_W:0], 1'b0};
		if (fold_sum >= full_two) begin
			scl_quo = {1'b0, fold_hi} + (FOLD_W+2)'(2);
			scl_rem = fold_sum - full_two;
		end else if (fold_sum >= full_one) begin
			scl_quo = {1'b0, fold_hi} + (FOLD_W+2)'(1);
			scl_rem = fold_sum - full_one;
		end else begin
			scl_quo = {1'b0, fold_hi};
			scl_rem = fold_sum;
		end
		round_up = (scl_rem > (FOLD_W+2)'(HALF_SCALE));
		rounded  = scl_quo + (FOLD_W+2)'(round_up);
		if (zero_q) begin
			avg_val = '0;
		end else if ((div_quo >= SAT_LIMIT) || rounded[AVG_W]) begin
			avg_val = '1;
		end else begin
			avg_val = rounded[AVG_W-1:0];
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.out_channel     <= 2'(cmd.ch);
			out_q.average_value   <= avg_val;
			out_q.interrupt_total <= irq_q[idx];
			out_q.last            <= (32'(cmd.ch) == CHANNELS - 1);
		end
	end

	assign status.cnt_zero = (cnt_q[idx] == '0);
	assign status.div_done = div_done;
	assign out_data        = out_q;

	// A new division never starts while one is in flight.
	assert property (@(posedge clk) disable iff (!arst_n) div_start |-> !div_busy)
		else $error("divider restarted while busy");

endmodule

// File: sv/msavg_ctrl.sv
// Controller: sequences sample updates and the per-channel result computation.
`timescale 1ns / 1ps

module msavg_ctrl
	import msavg_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_operation,
	output logic       in_stall,
	output logic       out_valid,
	input  logic       out_stall,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIV_AVG,
		ST_EMIT
	} state_t;

	state_t          state_q;
	logic [CH_W-1:0] ch_q;
	logic            out_valid_q;
	logic            in_accept;
	logic            out_free;
	logic            ch_last;

	always_comb begin
		in_accept = in_valid && (state_q == ST_IDLE);
		out_free  = !out_valid_q || !out_stall;
		ch_last   = (32'(ch_q) == CHANNELS - 1);
	end

	// Commands decoded from the current state.
	always_comb begin
		cmd               = '0;
		cmd.ch            = ch_q;
		cmd.sample_upd    = in_accept && (in_operation == OP_SAMPLE);
		cmd.chan_load     = (state_q == ST_LOAD);
		cmd.div_avg_start = (state_q == ST_LOAD) && !status.cnt_zero;
		cmd.out_load      = (state_q == ST_EMIT) && out_free;
	end

	// State, channel index and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ch_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept && (in_operation == OP_SEND)) begin
						ch_q    <= '0;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					state_q <= status.cnt_zero ? ST_EMIT : ST_DIV_AVG;
				end
				ST_DIV_AVG: begin
					if (status.div_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						if (ch_last) begin
							state_q <= ST_IDLE;
						end else begin
							ch_q    <= ch_q + 1'b1;
							state_q <= ST_LOAD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	// The output register is only loaded when its transaction is gone or leaving.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || !out_stall))
		else $error("output register overwritten");

	// A send tick starts the channel sweep at the first channel.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && (in_operation == OP_SEND)) |=> ((state_q == ST_LOAD) && (ch_q == '0)))
		else $error("send tick did not start at the first channel");

	// Divider completions only arrive while a division is awaited.
	assert property (@(posedge clk) disable iff (!arst_n)
		status.div_done |-> (state_q == ST_DIV_AVG))
		else $error("unexpected divider completion");

endmodule

// File: sv/multichannel_sample_averager_core.sv
// Top level of the four-channel block averager with scaling.
`timescale 1ns / 1ps

// Usage:
// The input channel (in_valid, in_stall, in_data) takes one transaction per
// sample or send tick. A sample transaction is absorbed in the cycle it is
// accepted: it counts an interrupt and, if the read succeeded, adds the
// zero-clamped sample to the channel sum and count. Samples can follow
// back to back, one per cycle, while in_stall is low.
// A send tick produces one output transaction per channel, in channel order,
// with last set on the final one, and clears the sums and counts.
// Each channel result takes a load state, a wait in the divide state for the
// 48-step bit-serial division by the sample count, and an emit state in which
// the division by full scale is done by a fold and compare. A channel with no
// samples skips the division. A send tick thus holds in_stall high until the
// last result is loaded; its first result is valid once channel 0 has passed
// through these states.
// The result sits in an output register; while out_stall is high the sweep
// waits at the next result and the held transaction does not change. After
// the last result is loaded, the next input is accepted even if that result
// still waits.
// Reset clears all sums, counts and interrupt totals and sets the scale to
// 61440. The scale register is written through scale_wr_en/scale_wr_data.

module multichannel_sample_averager_core
	import msavg_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               scale_wr_en,
	input  logic [SCALE_W-1:0] scale_wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  in_item_t           in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output out_item_t          out_data
);

	dp_cmd_t    cmd;
	dp_status_t status;

	// Controller.
	msavg_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_operation (in_data.operation),
		.in_stall     (in_stall),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.cmd          (cmd)
	);

	// Datapath.
	msavg_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.scale_wr_en   (scale_wr_en),
		.scale_wr_data (scale_wr_data),
		.in_data       (in_data),
		.cmd           (cmd),
		.status        (status),
		.out_data      (out_data)
	);

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for the multichannel sample averager core.
`timescale 1ns / 1ps

module tb;
	import msavg_pkg::*;

	// Run control.
	localparam int RESET_CYCLES   = 12;
	localparam int SETTLE_CYCLES  = 16;
	localparam int END_CYCLES     = 500;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PRINT_LIMIT    = 50;
	localparam int PHASE_ITEMS    = 69;
	localparam int COUNT_MAX      = (1 << COUNT_BITS) - 1;

	logic               clk;
	logic               arst_n;
	logic               scale_wr_en;
	logic [SCALE_W-1:0] scale_wr_data;
	logic               in_valid;
	logic               in_stall;
	in_item_t           in_data;
	logic               out_valid;
	logic               out_stall;
	out_item_t          out_data;

	// Model state of the averager.
	logic [SCALE_W-1:0] scale_reg;
	logic [SUM_W-1:0]   acc_sum   [CHANNELS];
	int unsigned        acc_count [CHANNELS];
	logic [IRQ_W-1:0]   irq_total [CHANNELS];

	// Averages that the block still owes, oldest first.
	out_item_t pending_averages[$];

	int  mismatch_count;
	bit  quiet;
	int  idle_cycles;

	multichannel_sample_averager_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.scale_wr_en   (scale_wr_en),
		.scale_wr_data (scale_wr_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_data       (in_data),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_data      (out_data)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Count a mismatch and print it while the log is still short.
	task automatic report_mismatch(string msg);
		if (mismatch_count < PRINT_LIMIT) begin
			$display("MISMATCH at %0t: %s", $realtime, msg);
		end
		mismatch_count++;
	endtask

	function automatic in_item_t make_item(logic op, int ch, int value, logic ok);
		in_item_t item;
		item.operation = op;
		item.channel   = 2'(ch);
		item.sample    = SAMPLE_W'(value);
		item.read_ok   = ok;
		return item;
	endfunction

	// Scaled average of one channel, rounded half up and saturated.
	function automatic logic [AVG_W-1:0] scaled_mean(int ch);
		longint unsigned prod, mean, quot;
		if (acc_count[ch] == 0) begin
			return '0;
		end
		prod = scale_reg;
		prod = prod * acc_sum[ch];
		mean = prod / acc_count[ch];
		quot = mean / 32767;
		if ((mean % 32767) > (32767 / 2)) begin
			quot++;
		end
		if (quot > 64'hFFFF) begin
			quot = 64'hFFFF;
		end
		return AVG_W'(quot);
	endfunction

	// Apply one accepted input transaction to the model.
	task automatic predict_item(in_item_t item);
		longint unsigned total;
		int unsigned     value;
		out_item_t       res;
		if (item.operation == OP_SAMPLE) begin
			irq_total[item.channel] = irq_total[item.channel] + 1;
			if (item.read_ok && acc_count[item.channel] < COUNT_MAX) begin
				value = item.sample[SAMPLE_W-1] ? 0 : int'(item.sample);
				total = acc_sum[item.channel];
				total = total + value;
				acc_sum[item.channel] = (total > 64'hFFFF_FFFF) ? '1 : SUM_W'(total);
				acc_count[item.channel]++;
			end
		end else begin
			for (int ch = 0; ch < CHANNELS; ch++) begin
				res.out_channel     = 2'(ch);
				res.average_value   = scaled_mean(ch);
				res.interrupt_total = irq_total[ch];
				res.last            = (ch == CHANNELS - 1);
				pending_averages.push_back(res);
				acc_sum[ch]   = '0;
				acc_count[ch] = 0;
			end
		end
	endtask

	// Send one input transaction, with an optional idle burst ahead of it.
	task automatic send_item(in_item_t item);
		int gap;
		gap = 0;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 12);
		end
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= item;
		do @(posedge clk); while (in_stall);
		predict_item(item);
	endtask

	// Drop valid and wait until every owed average has come out.
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_averages.size() > 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_scale(int value);
		wait_idle();
		@(negedge clk);
		scale_wr_en   <= 1'b1;
		scale_wr_data <= SCALE_W'(value);
		@(posedge clk);
		scale_reg = SCALE_W'(value);
		@(negedge clk);
		scale_wr_en <= 1'b0;
	endtask

	function automatic in_item_t random_item();
		in_item_t item;
		int       value;
		case ($urandom_range(0, 7))
			0: value = -32768;
			1: value = -1;
			2: value = 0;
			3: value = 32767;
			default: value = int'($urandom_range(0, 65535));
		endcase
		item = make_item(($urandom_range(0, 7) == 0) ? OP_SEND : OP_SAMPLE,
			$urandom_range(0, 3), value, ($urandom_range(0, 7) != 0));
		return item;
	endfunction

	// A tick straight after reset reports all zeros.
	task automatic test_reset_state();
		send_item(make_item(OP_SEND, 0, 0, 1'b0));
	endtask

	// Field extremes, negative clamping and failed reads.
	task automatic test_field_extremes();
		send_item(make_item(OP_SAMPLE, 0, 32767, 1'b1));
		send_item(make_item(OP_SAMPLE, 1, 0, 1'b1));
		send_item(make_item(OP_SAMPLE, 2, -32768, 1'b1));
		send_item(make_item(OP_SAMPLE, 3, -1, 1'b0));
		send_item(make_item(OP_SAMPLE, 1, 1, 1'b1));
		send_item(make_item(OP_SAMPLE, 0, 32767, 1'b0));
		send_item(make_item(OP_SAMPLE, 2, 12345, 1'b1));
		// The channel and sample of a tick carry no meaning.
		send_item(make_item(OP_SEND, 3, -1, 1'b1));
	endtask

	// Remainders just below and just above half of full scale.
	task automatic test_rounding_edges();
		write_scale(1);
		send_item(make_item(OP_SAMPLE, 0, 16384, 1'b1));
		send_item(make_item(OP_SAMPLE, 1, 16383, 1'b1));
		send_item(make_item(OP_SAMPLE, 2, 32767, 1'b1));
		send_item(make_item(OP_SAMPLE, 3, 1, 1'b1));
		send_item(make_item(OP_SAMPLE, 3, 0, 1'b1));
		send_item(make_item(OP_SEND, 0, 0, 1'b0));
	endtask

	// Largest and zero scale.
	task automatic test_scale_extremes();
		write_scale(65535);
		send_item(make_item(OP_SAMPLE, 0, 32767, 1'b1));
		send_item(make_item(OP_SAMPLE, 3, 100, 1'b1));
		send_item(make_item(OP_SEND, 1, 0, 1'b0));
		write_scale(0);
		send_item(make_item(OP_SAMPLE, 0, 32767, 1'b1));
		send_item(make_item(OP_SEND, 2, 0, 1'b0));
	endtask

	// Random traffic over several scale settings; the last phase runs flat out.
	task automatic test_random_traffic();
		int scales[5];
		scales[0] = 65535;
		scales[1] = 1;
		scales[2] = $urandom_range(1, 65535);
		scales[3] = 61440;
		scales[4] = $urandom_range(1, 65535);
		for (int phase = 0; phase < 5; phase++) begin
			write_scale(scales[phase]);
			quiet = (phase == 4);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				send_item(random_item());
			end
			send_item(make_item(OP_SEND, $urandom_range(0, 3), $urandom_range(0, 65535),
				1'(($urandom_range(0, 1)))));
		end
	endtask

	// Receiver stalls in random bursts.
	initial begin
		int burst;
		burst     = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!quiet && burst == 0 && $urandom_range(0, 7) == 0) begin
				burst = $urandom_range(1, 12);
			end
			if (quiet) begin
				burst = 0;
			end
			out_stall <= (burst > 0);
			if (burst > 0) begin
				burst--;
			end
		end
	end

	// Compare each output transaction with the oldest owed average.
	initial begin
		out_item_t want;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (pending_averages.size() == 0) begin
					report_mismatch($sformatf("unexpected result for channel %0d",
						out_data.out_channel));
				end else begin
					want = pending_averages.pop_front();
					if (out_data.out_channel !== want.out_channel) begin
						report_mismatch($sformatf("out_channel %0d, expected %0d",
							out_data.out_channel, want.out_channel));
					end
					if (out_data.average_value !== want.average_value) begin
						report_mismatch($sformatf("ch %0d average_value %0d, expected %0d",
							want.out_channel, out_data.average_value,
							want.average_value));
					end
					if (out_data.interrupt_total !== want.interrupt_total) begin
						report_mismatch($sformatf("ch %0d interrupt_total %0d, expected %0d",
							want.out_channel, out_data.interrupt_total,
							want.interrupt_total));
					end
					if (out_data.last !== want.last) begin
						report_mismatch($sformatf("ch %0d last %0b, expected %0b",
							want.out_channel, out_data.last, want.last));
					end
				end
			end
		end
	end

	// Watchdog on cycles with no transaction on either side.
	initial begin
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("RESULT: ERROR");
		$finish;
	end

	// Reset, run the tests in turn, drain and report.
	initial begin
		arst_n         = 1'b0;
		scale_wr_en    = 1'b0;
		scale_wr_data  = '0;
		in_valid       = 1'b0;
		in_data        = '0;
		quiet          = 1'b0;
		mismatch_count = 0;
		scale_reg      = SCALE_RESET;
		for (int ch = 0; ch < CHANNELS; ch++) begin
			acc_sum[ch]   = '0;
			acc_count[ch] = 0;
			irq_total[ch] = '0;
		end
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_field_extremes();
		test_rounding_edges();
		test_scale_extremes();
		test_random_traffic();

		wait_idle();
		repeat (END_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_averages.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
